### src/glyph_raster_to_serpentine_leds_unit_macros.svh
// Assertion shorthands for the block's modules; only the index unit uses them.
// Each expects signals named clk and arst_n in the using module.
`ifndef GLYPH_RASTER_TO_SERPENTINE_LEDS_UNIT_MACROS_SVH
`define GLYPH_RASTER_TO_SERPENTINE_LEDS_UNIT_MACROS_SVH

// Same-cycle implication.
`define GRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GRS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/grs_pkg.sv
package grs_pkg;

	// Field widths of the input and result words
	localparam int X_W     = 10;
	localparam int Y_W     = 7;
	localparam int CODE_W  = 8;
	localparam int COLOR_W = 24;
	localparam int IDX_W   = 13;

	// Config port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int ROWS_REG_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ROWS = 2'd3;

	localparam int PANEL_WIDTH_RST = 118;
	localparam int TOP_ROWS_RST    = 10;
	localparam int MIDDLE_ROWS_RST = 9;
	localparam int BOTTOM_ROWS_RST = 8;

	// Font geometry
	localparam int FIRST_CODE = 32;
	localparam int LAST_CODE  = 126;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_W    = 40;

	// One scan step handed from the sequencer to the index unit
	typedef struct packed {
		logic               hit;
		logic               flush;
		logic [X_W-1:0]     ux;
		logic [Y_W-1:0]     uy;
		logic [COLOR_W-1:0] color;
	} step_t;

	// Status back from the index unit
	typedef struct packed {
		logic stall;
		logic drained;
	} emit_stat_t;

	// Glyph columns packed {c4,c3,c2,c1,c0}; bit col*8+row, row 0 on top
	function automatic logic [GLYPH_W-1:0] glyph_cols(input logic [6:0] ofs);
		logic [GLYPH_W-1:0] g;
		case (ofs)
			7'd0:  g = 40'h00_00_00_00_00;
			7'd1:  g = 40'h00_00_5f_00_00;
			7'd2:  g = 40'h00_07_00_07_00;
			7'd3:  g = 40'h14_7f_14_7f_14;
			7'd4:  g = 40'h12_2a_7f_2a_24;
			7'd5:  g = 40'h62_64_08_13_23;
			7'd6:  g = 40'h50_22_55_49_36;
			7'd7:  g = 40'h00_00_03_05_00;
			7'd8:  g = 40'h00_41_22_1c_00;
			7'd9:  g = 40'h00_1c_22_41_00;
			7'd10: g = 40'h14_08_3e_08_14;
			7'd11: g = 40'h08_08_3e_08_08;
			7'd12: g = 40'h00_00_30_50_00;
			7'd13: g = 40'h08_08_08_08_08;
			7'd14: g = 40'h00_00_60_60_00;
			7'd15: g = 40'h02_04_08_10_20;
			7'd16: g = 40'h3e_45_49_51_3e;
			7'd17: g = 40'h00_40_7f_42_00;
			7'd18: g = 40'h46_49_51_61_42;
			7'd19: g = 40'h31_4b_45_41_21;
			7'd20: g = 40'h10_7f_12_14_18;
			7'd21: g = 40'h39_45_45_45_27;
			7'd22: g = 40'h30_49_49_4a_3c;
			7'd23: g = 40'h03_05_09_71_01;
			7'd24: g = 40'h36_49_49_49_36;
			7'd25: g = 40'h1e_29_49_49_06;
			7'd26: g = 40'h00_00_36_36_00;
			7'd27: g = 40'h00_00_36_56_00;
			7'd28: g = 40'h00_41_22_14_08;
			7'd29: g = 40'h14_14_14_14_14;
			7'd30: g = 40'h08_14_22_41_00;
			7'd31: g = 40'h06_09_51_01_02;
			7'd32: g = 40'h3e_41_79_49_32;
			7'd33: g = 40'h7e_11_11_11_7e;
			7'd34: g = 40'h36_49_49_49_7f;
			7'd35: g = 40'h22_41_41_41_3e;
			7'd36: g = 40'h1c_22_41_41_7f;
			7'd37: g = 40'h41_49_49_49_7f;
			7'd38: g = 40'h01_09_09_09_7f;
			7'd39: g = 40'h7a_49_49_41_3e;
			7'd40: g = 40'h7f_08_08_08_7f;
			7'd41: g = 40'h00_41_7f_41_00;
			7'd42: g = 40'h01_3f_41_40_20;
			7'd43: g = 40'h41_22_14_08_7f;
			7'd44: g = 40'h40_40_40_40_7f;
			7'd45: g = 40'h7f_02_0c_02_7f;
			7'd46: g = 40'h7f_10_08_04_7f;
			7'd47: g = 40'h3e_41_41_41_3e;
			7'd48: g = 40'h06_09_09_09_7f;
			7'd49: g = 40'h5e_21_51_41_3e;
			7'd50: g = 40'h46_29_19_09_7f;
			7'd51: g = 40'h31_49_49_49_46;
			7'd52: g = 40'h01_01_7f_01_01;
			7'd53: g = 40'h3f_40_40_40_3f;
			7'd54: g = 40'h1f_20_40_20_1f;
			7'd55: g = 40'h3f_40_38_40_3f;
			7'd56: g = 40'h63_14_08_14_63;
			7'd57: g = 40'h07_08_70_08_07;
			7'd58: g = 40'h43_45_49_51_61;
			7'd59: g = 40'h00_41_41_7f_00;
			7'd60: g = 40'h20_10_08_04_02;
			7'd61: g = 40'h00_7f_41_41_00;
			7'd62: g = 40'h04_02_01_02_04;
			7'd63: g = 40'h40_40_40_40_40;
			7'd64: g = 40'h00_04_02_01_00;
			7'd65: g = 40'h78_54_54_54_20;
			7'd66: g = 40'h38_44_44_48_7f;
			7'd67: g = 40'h20_44_44_44_38;
			7'd68: g = 40'h7f_48_44_44_38;
			7'd69: g = 40'h18_54_54_54_38;
			7'd70: g = 40'h02_01_09_7e_08;
			7'd71: g = 40'h3e_52_52_52_0c;
			7'd72: g = 40'h78_04_04_08_7f;
			7'd73: g = 40'h00_40_7d_44_00;
			7'd74: g = 40'h00_3d_44_40_20;
			7'd75: g = 40'h00_44_28_10_7f;
			7'd76: g = 40'h00_40_7f_41_00;
			7'd77: g = 40'h78_04_18_04_7c;
			7'd78: g = 40'h78_04_04_08_7c;
			7'd79: g = 40'h38_44_44_44_38;
			7'd80: g = 40'h08_14_14_14_7c;
			7'd81: g = 40'h7c_18_14_14_08;
			7'd82: g = 40'h08_04_04_08_7c;
			7'd83: g = 40'h20_54_54_54_48;
			7'd84: g = 40'h20_40_44_3f_04;
			7'd85: g = 40'h7c_20_40_40_3c;
			7'd86: g = 40'h1c_20_40_20_1c;
			7'd87: g = 40'h3c_40_30_40_3c;
			7'd88: g = 40'h44_28_10_28_44;
			7'd89: g = 40'h3c_50_50_50_0c;
			7'd90: g = 40'h44_4c_54_64_44;
			7'd91: g = 40'h00_41_36_08_00;
			7'd92: g = 40'h00_00_7f_00_00;
			7'd93: g = 40'h00_08_36_41_00;
			7'd94: g = 40'h08_10_08_08_10;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

### src/grs_ifs.sv
// Glyph draw request channel
interface grs_req_if;
	logic                              valid;
	logic                              ready;
	logic signed [grs_pkg::X_W-1:0]    origin_x;
	logic signed [grs_pkg::Y_W-1:0]    origin_y;
	logic [grs_pkg::CODE_W-1:0]        char_code;
	logic [grs_pkg::COLOR_W-1:0]       pixel_color;

	modport source(output valid, origin_x, origin_y, char_code, pixel_color, input ready);
	modport sink(input valid, origin_x, origin_y, char_code, pixel_color, output ready);
endinterface

// LED pixel result channel
interface grs_pix_if;
	logic                         valid;
	logic                         ready;
	logic [grs_pkg::IDX_W-1:0]    led_index;
	logic [grs_pkg::COLOR_W-1:0]  led_color;
	logic                         last_pixel;

	modport source(output valid, led_index, led_color, last_pixel, input ready);
	modport sink(input valid, led_index, led_color, last_pixel, output ready);
endinterface

### src/grs_scan.sv
// Scan sequencer: walks the 5x7 glyph one bit a cycle, unless the index unit stalls it, and clips it.
module grs_scan #(
	parameter int WW = 8,
	parameter int RW = 5,
	parameter int TW = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	grs_req_if.sink                 req,
	input  logic [WW-1:0]           w,
	input  logic [RW-1:0]           r0,
	input  logic [RW-1:0]           r1,
	input  logic [RW-1:0]           r2,
	input  grs_pkg::emit_stat_t     stat,
	output grs_pkg::step_t          step
);

	localparam int CX = (WW > grs_pkg::X_W) ? WW : grs_pkg::X_W;
	localparam int CY = (TW > grs_pkg::Y_W) ? TW : grs_pkg::Y_W;
	localparam logic [2:0] COL_LAST = 3'(grs_pkg::GLYPH_COLS - 1);
	localparam logic [2:0] ROW_LAST = 3'(grs_pkg::GLYPH_ROWS - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t                        state_q;
	logic [grs_pkg::GLYPH_W-1:0]   glyph_q;
	logic [grs_pkg::X_W-1:0]       ox_q;
	logic [grs_pkg::Y_W-1:0]       oy_q;
	logic [grs_pkg::COLOR_W-1:0]   color_q;
	logic [2:0]                    col_q;
	logic [2:0]                    row_q;

	logic                          accept;
	logic                          in_font;
	logic [grs_pkg::CODE_W-1:0]    code_ofs;
	logic [grs_pkg::X_W:0]         px;
	logic [grs_pkg::Y_W:0]         py;
	logic [TW-1:0]                 total;
	logic                          vis_x;
	logic                          vis_y;
	logic                          lit;
	logic                          advance;
	logic                          last_bit;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// Font lookup on the incoming code
	assign in_font  = req.char_code inside
		{[8'(grs_pkg::FIRST_CODE) : 8'(grs_pkg::LAST_CODE)]};
	assign code_ofs = req.char_code - 8'(grs_pkg::FIRST_CODE);

	// Pixel position of the current bit and its clip test
	assign px    = {ox_q[grs_pkg::X_W-1], ox_q} + (grs_pkg::X_W+1)'(col_q);
	assign py    = {oy_q[grs_pkg::Y_W-1], oy_q} + (grs_pkg::Y_W+1)'(row_q);
	assign total = TW'(r0) + TW'(r1) + TW'(r2);
	assign vis_x = !px[grs_pkg::X_W] && (CX'(px[grs_pkg::X_W-1:0]) < CX'(w));
	assign vis_y = !py[grs_pkg::Y_W] && (CY'(py[grs_pkg::Y_W-1:0]) < CY'(total));
	assign lit   = glyph_q[{col_q, row_q}];

	assign step.hit   = (state_q == S_SCAN) && lit && vis_x && vis_y;
	assign step.flush = (state_q == S_FLUSH);
	assign step.ux    = px[grs_pkg::X_W-1:0];
	assign step.uy    = py[grs_pkg::Y_W-1:0];
	assign step.color = color_q;

	assign advance  = (state_q == S_SCAN) && !stat.stall;
	assign last_bit = (col_q == COL_LAST) && (row_q == ROW_LAST);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						col_q   <= '0;
						row_q   <= '0;
					end
				end
				S_SCAN: begin
					if (advance) begin
						if (last_bit) begin
							state_q <= S_FLUSH;
						end else if (row_q == ROW_LAST) begin
							row_q <= '0;
							col_q <= col_q + 3'd1;
						end else begin
							row_q <= row_q + 3'd1;
						end
					end
				end
				S_FLUSH: begin
					if (stat.drained) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the request word
	always_ff @(posedge clk) begin
		if (accept) begin
			glyph_q <= in_font ? grs_pkg::glyph_cols(code_ofs[6:0]) : '0;
			ox_q    <= req.origin_x;
			oy_q    <= req.origin_y;
			color_q <= req.pixel_color;
		end
	end

endmodule

### src/grs_emit.sv
`include "glyph_raster_to_serpentine_leds_unit_macros.svh"

// Index unit: maps a visible pixel to its strip position and holds one
// pixel back so the final one can be flagged.
module grs_emit #(
	parameter int WW = 8,
	parameter int RW = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  grs_pkg::step_t          step,
	input  logic [WW-1:0]           w,
	input  logic [RW-1:0]           r0,
	input  logic [RW-1:0]           r1,
	output grs_pkg::emit_stat_t     stat,
	grs_pix_if.source               pix
);

	localparam int EY = (RW + 2 > grs_pkg::Y_W) ? RW + 2 : grs_pkg::Y_W;
	localparam int LW = (WW + grs_pkg::Y_W + 1 > grs_pkg::IDX_W) ?
		WW + grs_pkg::Y_W + 1 : grs_pkg::IDX_W;

	logic [EY-1:0]                 uy_e;
	logic [EY-1:0]                 lim0;
	logic [EY-1:0]                 lim1;
	logic [EY-1:0]                 local_row;
	logic [WW-1:0]                 ux_w;
	logic [WW-1:0]                 serp;
	logic [LW-1:0]                 idx_full;

	logic                          held_v_q;
	logic [grs_pkg::IDX_W-1:0]     held_idx_q;
	logic [grs_pkg::COLOR_W-1:0]   held_color_q;
	logic                          out_v_q;
	logic [grs_pkg::IDX_W-1:0]     out_idx_q;
	logic [grs_pkg::COLOR_W-1:0]   out_color_q;
	logic                          out_last_q;

	logic                          out_free;
	logic                          take_new;
	logic                          push_mid;
	logic                          push_last;

	// Row within its panel; its parity sets the zigzag direction
	assign uy_e      = EY'(step.uy);
	assign lim0      = EY'(r0);
	assign lim1      = EY'(r0) + EY'(r1);
	assign local_row = (uy_e < lim0) ? uy_e :
	                   (uy_e < lim1) ? (uy_e - lim0) : (uy_e - lim1);
	assign ux_w      = WW'(step.ux);
	assign serp      = local_row[0] ? (w - WW'(1) - ux_w) : ux_w;

	// Panels chain back to back, so the strip position is w * row + offset
	assign idx_full  = LW'(w) * LW'(step.uy) + LW'(serp);

	// Handshake between scan, hold stage and output register
	assign out_free  = !out_v_q || pix.ready;
	assign take_new  = step.hit && (!held_v_q || out_free);
	assign push_mid  = step.hit && held_v_q && out_free;
	assign push_last = step.flush && held_v_q && out_free;

	assign stat.stall   = step.hit && held_v_q && !out_free;
	assign stat.drained = !held_v_q || out_free;

	// Hold stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
		end else if (take_new) begin
			held_v_q <= 1'b1;
		end else if (push_last) begin
			held_v_q <= 1'b0;
		end
	end

	// Hold stage word
	always_ff @(posedge clk) begin
		if (take_new) begin
			held_idx_q   <= idx_full[grs_pkg::IDX_W-1:0];
			held_color_q <= step.color;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= push_mid || push_last;
		end
	end

	// Output register word
	always_ff @(posedge clk) begin
		if (push_mid || push_last) begin
			out_idx_q   <= held_idx_q;
			out_color_q <= held_color_q;
			out_last_q  <= push_last;
		end
	end

	assign pix.valid      = out_v_q;
	assign pix.led_index  = out_idx_q;
	assign pix.led_color  = out_color_q;
	assign pix.last_pixel = out_last_q;

	`GRS_ASSERT_NXT(a_stall_holds, stat.stall, held_v_q && $stable(held_idx_q),
		"held pixel changed during stall")
	`GRS_ASSERT_NXT(a_flush_flags_last, push_last,
		out_v_q && out_last_q && !held_v_q, "final pixel not flagged")
	`GRS_ASSERT_NXT(a_mid_not_last, push_mid,
		out_v_q && !out_last_q && held_v_q, "inner pixel flagged as last")
	`GRS_ASSERT_IMP(a_no_hit_in_flush, step.flush, !step.hit,
		"lit pixel seen after scan end")

endmodule

### src/glyph_raster_to_serpentine_leds_unit.sv
// Channel  Dir  Contents
// req      in   origin_x, origin_y, char_code, pixel_color
// pix      out  led_index, led_color, last_pixel
// cfg_*    in   register write: cfg_we, cfg_index, cfg_data
//
// A glyph is accepted, its 5x7 font bits are scanned one per cycle unless
// output back-pressure stalls them, and the held last pixel is then released.
// req.ready is high only while no glyph is in progress. Reset clears control
// state and loads the default panel geometry. A full output register stalls
// the scan only on a lit, visible bit.
module glyph_raster_to_serpentine_leds_unit #(
	parameter int MAX_COLUMNS    = 128,
	parameter int MAX_PANEL_ROWS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [grs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [grs_pkg::CFG_DATA_W-1:0]    cfg_data,
	grs_req_if.sink                           req,
	grs_pix_if.source                         pix
);

	localparam int WW = $clog2(MAX_COLUMNS + 1);
	localparam int RW = $clog2(MAX_PANEL_ROWS + 1);
	localparam int TW = $clog2(3 * MAX_PANEL_ROWS + 1);

	localparam int W_RST  = (grs_pkg::PANEL_WIDTH_RST > MAX_COLUMNS) ?
		MAX_COLUMNS : grs_pkg::PANEL_WIDTH_RST;
	localparam int R0_RST = (grs_pkg::TOP_ROWS_RST > MAX_PANEL_ROWS) ?
		MAX_PANEL_ROWS : grs_pkg::TOP_ROWS_RST;
	localparam int R1_RST = (grs_pkg::MIDDLE_ROWS_RST > MAX_PANEL_ROWS) ?
		MAX_PANEL_ROWS : grs_pkg::MIDDLE_ROWS_RST;
	localparam int R2_RST = (grs_pkg::BOTTOM_ROWS_RST > MAX_PANEL_ROWS) ?
		MAX_PANEL_ROWS : grs_pkg::BOTTOM_ROWS_RST;

	logic [WW-1:0]          w_q;
	logic [RW-1:0]          r0_q;
	logic [RW-1:0]          r1_q;
	logic [RW-1:0]          r2_q;
	logic [WW-1:0]          w_sat;
	logic [RW-1:0]          rows_sat;
	grs_pkg::step_t         step;
	grs_pkg::emit_stat_t    stat;

	// Saturate written values to the build limits
	assign w_sat    = (int'(cfg_data) > MAX_COLUMNS) ? WW'(MAX_COLUMNS) : WW'(cfg_data);
	assign rows_sat = (int'(cfg_data[grs_pkg::ROWS_REG_W-1:0]) > MAX_PANEL_ROWS) ?
		RW'(MAX_PANEL_ROWS) : RW'(cfg_data[grs_pkg::ROWS_REG_W-1:0]);

	// Geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= WW'(W_RST);
			r0_q <= RW'(R0_RST);
			r1_q <= RW'(R1_RST);
			r2_q <= RW'(R2_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				grs_pkg::CFG_PANEL_WIDTH: w_q  <= w_sat;
				grs_pkg::CFG_TOP_ROWS:    r0_q <= rows_sat;
				grs_pkg::CFG_MIDDLE_ROWS: r1_q <= rows_sat;
				grs_pkg::CFG_BOTTOM_ROWS: r2_q <= rows_sat;
				default: ;
			endcase
		end
	end

	grs_scan #(
		.WW(WW),
		.RW(RW),
		.TW(TW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.w      (w_q),
		.r0     (r0_q),
		.r1     (r1_q),
		.r2     (r2_q),
		.stat   (stat),
		.step   (step)
	);

	grs_emit #(
		.WW(WW),
		.RW(RW)
	) u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.w      (w_q),
		.r0     (r0_q),
		.r1     (r1_q),
		.stat   (stat),
		.pix    (pix)
	);

endmodule

### tb/tb_glyph_raster_to_serpentine_leds_unit.sv
module tb_glyph_raster_to_serpentine_leds_unit;
	import grs_pkg::*;

	localparam int COLUMN_CAP   = 128;
	localparam int ROW_CAP      = 16;
	localparam int DRAIN_CYCLES = 45;
	localparam int RUN_LIMIT    = 1_000_000;

	// 5x7 font, five column bytes per glyph, bit 0 is the top row
	localparam logic [7:0] FONT_COLS [0:474] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5f,8'h00,8'h00,
		8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7f,8'h14,8'h7f,8'h14,
		8'h24,8'h2a,8'h7f,8'h2a,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
		8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
		8'h00,8'h1c,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1c,8'h00,
		8'h14,8'h08,8'h3e,8'h08,8'h14, 8'h08,8'h08,8'h3e,8'h08,8'h08,
		8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
		8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
		8'h3e,8'h51,8'h49,8'h45,8'h3e, 8'h00,8'h42,8'h7f,8'h40,8'h00,
		8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4b,8'h31,
		8'h18,8'h14,8'h12,8'h7f,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
		8'h3c,8'h4a,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
		8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1e,
		8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
		8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
		8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06,
		8'h32,8'h49,8'h79,8'h41,8'h3e, 8'h7e,8'h11,8'h11,8'h11,8'h7e,
		8'h7f,8'h49,8'h49,8'h49,8'h36, 8'h3e,8'h41,8'h41,8'h41,8'h22,
		8'h7f,8'h41,8'h41,8'h22,8'h1c, 8'h7f,8'h49,8'h49,8'h49,8'h41,
		8'h7f,8'h09,8'h09,8'h09,8'h01, 8'h3e,8'h41,8'h49,8'h49,8'h7a,
		8'h7f,8'h08,8'h08,8'h08,8'h7f, 8'h00,8'h41,8'h7f,8'h41,8'h00,
		8'h20,8'h40,8'h41,8'h3f,8'h01, 8'h7f,8'h08,8'h14,8'h22,8'h41,
		8'h7f,8'h40,8'h40,8'h40,8'h40, 8'h7f,8'h02,8'h0c,8'h02,8'h7f,
		8'h7f,8'h04,8'h08,8'h10,8'h7f, 8'h3e,8'h41,8'h41,8'h41,8'h3e,
		8'h7f,8'h09,8'h09,8'h09,8'h06, 8'h3e,8'h41,8'h51,8'h21,8'h5e,
		8'h7f,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
		8'h01,8'h01,8'h7f,8'h01,8'h01, 8'h3f,8'h40,8'h40,8'h40,8'h3f,
		8'h1f,8'h20,8'h40,8'h20,8'h1f, 8'h3f,8'h40,8'h38,8'h40,8'h3f,
		8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
		8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7f,8'h41,8'h41,8'h00,
		8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7f,8'h00,
		8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
		8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
		8'h7f,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
		8'h38,8'h44,8'h44,8'h48,8'h7f, 8'h38,8'h54,8'h54,8'h54,8'h18,
		8'h08,8'h7e,8'h09,8'h01,8'h02, 8'h0c,8'h52,8'h52,8'h52,8'h3e,
		8'h7f,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7d,8'h40,8'h00,
		8'h20,8'h40,8'h44,8'h3d,8'h00, 8'h7f,8'h10,8'h28,8'h44,8'h00,
		8'h00,8'h41,8'h7f,8'h40,8'h00, 8'h7c,8'h04,8'h18,8'h04,8'h78,
		8'h7c,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
		8'h7c,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7c,
		8'h7c,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
		8'h04,8'h3f,8'h44,8'h40,8'h20, 8'h3c,8'h40,8'h40,8'h20,8'h7c,
		8'h1c,8'h20,8'h40,8'h20,8'h1c, 8'h3c,8'h40,8'h30,8'h40,8'h3c,
		8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0c,8'h50,8'h50,8'h50,8'h3c,
		8'h44,8'h64,8'h54,8'h4c,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
		8'h00,8'h00,8'h7f,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
		8'h10,8'h08,8'h08,8'h10,8'h08
	};

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] color;
		logic               last;
	} led_pixel_t;

	// Panel geometry copy, glyph rasterizer and queue of LED writes still owed
	class lit_pixel_ledger;
		logic [7:0]   width_reg;
		logic [4:0]   top_reg, middle_reg, bottom_reg;
		led_pixel_t   pending_pixels[$];
		int           requests, checked, errors;

		function new();
			width_reg  = PANEL_WIDTH_RST;
			top_reg    = TOP_ROWS_RST;
			middle_reg = MIDDLE_ROWS_RST;
			bottom_reg = BOTTOM_ROWS_RST;
			requests   = 0;
			checked    = 0;
			errors     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_PANEL_WIDTH: width_reg  = data;
				CFG_TOP_ROWS:    top_reg    = data[4:0];
				CFG_MIDDLE_ROWS: middle_reg = data[4:0];
				CFG_BOTTOM_ROWS: bottom_reg = data[4:0];
				default: ;
			endcase
		endfunction

		function int capped(int v, int hi);
			return (v > hi) ? hi : v;
		endfunction

		function int span_cols();
			return capped(width_reg, COLUMN_CAP);
		endfunction

		function int span_rows();
			return capped(top_reg, ROW_CAP) + capped(middle_reg, ROW_CAP)
				+ capped(bottom_reg, ROW_CAP);
		endfunction

		// zigzag: even rows left to right, odd rows right to left
		function int snake(int col, int row, int w);
			if (row % 2 == 0)
				return row * w + col;
			return row * w + (w - 1 - col);
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// Rasterize one accepted draw request into the LED writes it owes
		function void note_request(logic signed [X_W-1:0] ox, logic signed [Y_W-1:0] oy,
				logic [CODE_W-1:0] code, logic [COLOR_W-1:0] color);
			led_pixel_t glyph_pixels[$];
			led_pixel_t p;
			logic [7:0] bits;
			int         x0, y0, w, r0, r1, r2, px, py, lin;
			requests++;
			if (code < FIRST_CODE || code > LAST_CODE)
				return;
			x0 = ox;
			y0 = oy;
			w  = span_cols();
			r0 = capped(top_reg, ROW_CAP);
			r1 = capped(middle_reg, ROW_CAP);
			r2 = capped(bottom_reg, ROW_CAP);
			for (int c = 0; c < GLYPH_COLS; c++) begin
				bits = FONT_COLS[(code - FIRST_CODE) * GLYPH_COLS + c];
				px = x0 + c;
				for (int r = 0; r < GLYPH_ROWS; r++) begin
					py = y0 + r;
					if (bits[r] && px >= 0 && px < w && py >= 0 && py < r0 + r1 + r2) begin
						if (py < r0)
							lin = snake(px, py, w);
						else if (py < r0 + r1)
							lin = w * r0 + snake(px, py - r0, w);
						else
							lin = w * (r0 + r1) + snake(px, py - r0 - r1, w);
						p.idx   = lin[IDX_W-1:0];
						p.color = color;
						p.last  = 1'b0;
						glyph_pixels.push_back(p);
					end
				end
			end
			// flag the final visible pixel of the glyph
			foreach (glyph_pixels[i]) begin
				p = glyph_pixels[i];
				p.last = (i == glyph_pixels.size() - 1);
				pending_pixels.push_back(p);
			end
		endfunction

		function void check_pixel(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] color,
				logic last);
			led_pixel_t want;
			checked++;
			if (pending_pixels.size() == 0) begin
				if (errors < 10)
					$display("[%0t] unexpected pixel: index %0d color %06h last %0b",
						$realtime, idx, color, last);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			if (want.idx !== idx || want.color !== color || want.last !== last) begin
				if (errors < 10)
					$display("[%0t] pixel mismatch: exp index %0d color %06h last %0b, got index %0d color %06h last %0b",
						$realtime, want.idx, want.color, want.last, idx, color, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	grs_req_if req_ch();
	grs_pix_if pix_ch();

	lit_pixel_ledger board;
	int tx_idle_pct = 33;
	int rx_idle_pct = 67;
	int rx_hold     = 0;
	int geometries  = 1;
	int cycle_count = 0;

	glyph_raster_to_serpentine_leds_unit #(
		.MAX_COLUMNS   (COLUMN_CAP),
		.MAX_PANEL_ROWS(ROW_CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.pix      (pix_ch)
	);

	always #5 clk = ~clk;

	// Result side: drop ready at random or for a counted hold-off
	initial begin
		pix_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Check every accepted pixel word
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready)
			board.check_pixel(pix_ch.led_index, pix_ch.led_color, pix_ch.last_pixel);
	end

	// Abort a hung run
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Offer one draw request, with random idle cycles ahead of it, until accepted
	task automatic send_glyph(input logic signed [X_W-1:0] ox,
			input logic signed [Y_W-1:0] oy, input logic [CODE_W-1:0] code,
			input logic [COLOR_W-1:0] color);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid       <= 1'b0;
			req_ch.origin_x    <= $urandom;
			req_ch.origin_y    <= $urandom;
			req_ch.char_code   <= $urandom;
			req_ch.pixel_color <= $urandom;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.origin_x    <= ox;
		req_ch.origin_y    <= oy;
		req_ch.char_code   <= code;
		req_ch.pixel_color <= color;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		board.note_request(ox, oy, code, color);
	endtask

	// Drop valid and wait for every owed pixel
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	// Drain, then let any glyph with no visible pixel finish its scan
	task automatic settle();
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		board.set_reg(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input logic [7:0] width, input logic [7:0] top,
			input logic [7:0] middle, input logic [7:0] bottom);
		settle();
		write_reg(CFG_PANEL_WIDTH, width);
		write_reg(CFG_TOP_ROWS, top);
		write_reg(CFG_MIDDLE_ROWS, middle);
		write_reg(CFG_BOTTOM_ROWS, bottom);
		geometries++;
	endtask

	// Mostly printable glyphs aimed around the display, some raw noise
	task automatic draw_random(input int count);
		int x0, y0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 85) begin
				x0 = int'($urandom_range(board.span_cols() + 5)) - 5;
				y0 = int'($urandom_range(board.span_rows() + 7)) - 7;
				send_glyph(x0, y0, $urandom_range(LAST_CODE, FIRST_CODE), $urandom);
			end else begin
				send_glyph($urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		board = new();
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_PANEL_WIDTH;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.origin_x    = '0;
		req_ch.origin_y    = '0;
		req_ch.char_code   = '0;
		req_ch.pixel_color = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default geometry: 118 wide, 10 + 9 + 8 rows
		send_glyph(0, 0, 8'd0, 24'h123456);
		send_glyph(0, 0, 8'd31, 24'h654321);
		send_glyph(0, 0, 8'd127, 24'habcdef);
		send_glyph(511, 63, 8'd255, 24'hffffff);
		send_glyph(3, 2, 8'd32, 24'h00ff00);
		send_glyph(0, 0, "A", 24'hff0000);
		send_glyph(-2, -3, "#", 24'h000000);
		send_glyph(-512, -64, "@", 24'hffffff);
		send_glyph(511, 63, "W", 24'h0000ff);
		send_glyph(115, 5, "M", 24'h00ff00);
		send_glyph(50, 24, "B", 24'h808080);
		send_glyph(20, 7, "8", 24'h7f7f7f);
		send_glyph(60, 16, "%", 24'h010203);
		send_glyph(117, 0, "~", 24'hfedcba);
		send_glyph(0, 20, "!", 24'h5a5a5a);
		send_glyph(-3, 10, "|", 24'ha5a5a5);
		send_glyph(5, -6, "_", 24'hc0ffee);
		send_glyph(-1, 26, "g", 24'h00beef);
		send_glyph(113, 20, 8'd126, 24'hffffff);
		draw_random(50);

		// Long receiver hold-off while requests keep coming
		rx_hold = 400;
		draw_random(8);

		set_geometry(8'd1, 8'd1, 8'd1, 8'd1);
		send_glyph(0, 0, "#", 24'h112233);
		draw_random(25);

		// Sender idles more than the receiver from here
		tx_idle_pct = 67;
		rx_idle_pct = 33;
		set_geometry(8'd128, 8'd16, 8'd16, 8'd16);
		send_glyph(123, 41, "#", 24'h445566);
		draw_random(45);

		// Above-range values saturate
		set_geometry(8'd255, 8'hff, 8'd17, 8'd30);
		send_glyph(124, 44, "@", 24'h778899);
		draw_random(25);
		drain();
		draw_random(10);

		// No idling on either side
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_geometry(8'd0, 8'd5, 8'd6, 8'd7);
		send_glyph(0, 0, "#", 24'hdeadbe);
		draw_random(8);

		// Empty top and bottom panels, top written with only high bits set
		set_geometry(8'd40, 8'h20, 8'd7, 8'd0);
		send_glyph(0, 0, "#", 24'h13579b);
		draw_random(25);

		for (int k = 0; k < 3; k++) begin
			set_geometry($urandom, $urandom, $urandom, $urandom);
			draw_random(20);
		end

		settle();
		$display("Drew %0d glyph requests over %0d panel geometries and three idle patterns.",
			board.requests, geometries);
		$display("Checked %0d LED pixel words, %0d mismatches.", board.checked, board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/grs_pkg.sv
src/grs_ifs.sv
src/grs_scan.sv
src/grs_emit.sv
src/glyph_raster_to_serpentine_leds_unit.sv
tb/tb_glyph_raster_to_serpentine_leds_unit.sv
